### rtl/plt_pkg.sv
package plt_pkg;

    // input event selector codes
    localparam logic [2:0] FUNC_PING_REQ = 3'd0;
    localparam logic [2:0] FUNC_TX_DONE  = 3'd1;
    localparam logic [2:0] FUNC_RX_PKT   = 3'd2;
    localparam logic [2:0] FUNC_TICK     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;
    localparam logic [2:0] FUNC_READ     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_FRAME_LEN = 2'd1;
    localparam logic [1:0] CFG_MAGIC     = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET   = 32'd1000000;
    localparam logic [7:0]  FRAME_LEN_RESET = 8'd44;
    localparam logic [7:0]  MAGIC_RESET     = 8'hA5;

    // packet type byte
    localparam logic [7:0] TYPE_PING = 8'h01;
    localparam logic [7:0] TYPE_PONG = 8'h02;

    // statistic indexes
    localparam logic [3:0] STAT_PING_TX   = 4'd0;
    localparam logic [3:0] STAT_PING_RX   = 4'd1;
    localparam logic [3:0] STAT_PONG_TX   = 4'd2;
    localparam logic [3:0] STAT_PONG_RX   = 4'd3;
    localparam logic [3:0] STAT_TIMEOUT   = 4'd4;
    localparam logic [3:0] STAT_LAST_RTT  = 4'd5;
    localparam logic [3:0] STAT_MIN_RTT   = 4'd6;
    localparam logic [3:0] STAT_MAX_RTT   = 4'd7;
    localparam logic [3:0] STAT_RTT_TOTAL = 4'd8;
    localparam logic [3:0] STAT_SAMPLES   = 4'd9;
    localparam logic [3:0] STAT_OUT_SEQ   = 4'd10;
    localparam logic [3:0] STAT_OUT_TIME  = 4'd11;

    // event counter slots
    localparam int CNT_PING_TX = 0;
    localparam int CNT_PING_RX = 1;
    localparam int CNT_PONG_TX = 2;
    localparam int CNT_PONG_RX = 3;
    localparam int CNT_TIMEOUT = 4;
    localparam int NUM_CNT     = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PING_REQ,
        OP_TX_PING,
        OP_TX_PONG,
        OP_RX_PING,
        OP_RX_PONG,
        OP_TICK,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_us;
        logic        tx_ok;
        logic        tx_was_pong;
        logic [7:0]  rx_length;
        logic [7:0]  rx_magic;
        logic [7:0]  rx_type;
        logic [31:0] rx_seq;
        logic [31:0] rx_timestamp;
        logic        restart;
        logic [3:0]  stat_index;
    } in_item_t;

    typedef struct packed {
        logic        tx_request;
        logic        tx_is_pong;
        logic [31:0] tx_seq;
        logic [31:0] tx_timestamp;
        logic        rtt_valid;
        logic [31:0] rtt_us;
        logic        timeout_event;
        logic        ping_outstanding;
        logic [63:0] stat_value;
    } result_t;

    // classified command between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] now_us;
        logic [31:0] rx_seq;
        logic [31:0] rx_timestamp;
        logic        restart;
        logic [3:0]  stat_index;
    } cmd_t;

endpackage

### rtl/ping_pong_rtt_link_tester_core.sv
// ping/pong round-trip link test engine
//
// input channel: an item is one timestamped event (ping request, transmit
// done, received packet header, timer tick, statistics clear or read); it is
// taken at a clock edge with push high and full low
// result channel: exactly one result item per input item, in order; the
// oldest result sits on result while empty is low and leaves on pop
// config channel: cfg_valid/cfg_ready with cfg_index (0 timeout, 1 frame
// length, 2 magic byte) and cfg_data; cfg_ready is always high, and writes
// are meant for idle periods only
// path: an item is registered in the command queue, then the back end writes
// its result into the result queue, which drives the result ports
// throughput: one item per clock while the result queue has room; when it is
// full the back end holds
// reset: rst_n clears the queues, the link state and the statistics; min rtt
// resets to all ones and config returns to 1000000 us, 44 bytes and 0xa5
// stall: when pop stays low the result queue fills, the back end holds, then
// the command queue fills and full rises; nothing is dropped
module ping_pong_rtt_link_tester_core
    import plt_pkg::*;
#(
    parameter int CMD_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // event input
    input  logic        push,
    output logic        full,
    input  in_item_t    item,
    // result output
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CmdW = $bits(cmd_t);
    localparam int ResW = $bits(result_t);

    cmd_t        front_cmd;
    cmd_t        back_cmd;
    logic [31:0] timeout_us;
    logic        cmd_empty;
    logic        res_full;
    logic        back_go;
    result_t     back_result;
    logic        cmd_full;
    logic [CmdW-1:0] cmd_rdata;
    logic [ResW-1:0] res_rdata;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;

    // front end: config registers and event classification
    plt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (front_cmd),
        .timeout_us (timeout_us)
    );

    // short command queue decouples classification from execution
    plt_fifo #(
        .Width (CmdW),
        .Depth (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_cmd),
        .full  (cmd_full),
        .pop   (back_go),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign back_cmd = cmd_t'(cmd_rdata);

    // back end runs one command per cycle while there is room for its result
    assign back_go = !cmd_empty && !res_full;

    plt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (back_go),
        .cmd        (back_cmd),
        .timeout_us (timeout_us),
        .result     (back_result)
    );

    // result queue buffers results while the consumer stalls, until it fills
    plt_fifo #(
        .Width (ResW),
        .Depth (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_go),
        .wdata (back_result),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign result = result_t'(res_rdata);

endmodule

### rtl/plt_fifo.sv
module plt_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [Width-1:0] rdata,
    output logic             empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CntW'(Depth));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(Depth))
        else $error("queue fill count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == CntW'(Depth)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("pop did not lower fill count");

endmodule

### rtl/plt_front.sv
module plt_front
    import plt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    item,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cmd_t        cmd,
    output logic [31:0] timeout_us
);

    logic [31:0] timeout_reg;
    logic [7:0]  frame_len_reg;
    logic [7:0]  magic_reg;
    logic        hdr_ok;

    // config writes land only while the block is idle: the user is bound by this, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            frame_len_reg <= FRAME_LEN_RESET;
            magic_reg     <= MAGIC_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                CFG_FRAME_LEN: frame_len_reg <= cfg_data[7:0];
                CFG_MAGIC:     magic_reg     <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign timeout_us = timeout_reg;
    assign hdr_ok     = (item.rx_length == frame_len_reg) && (item.rx_magic == magic_reg);

    // classify the event; failed transmits, bad headers, unknown packet types and spare codes become a nop
    always_comb
    begin
        cmd.op           = OP_NOP;
        cmd.now_us       = item.now_us;
        cmd.rx_seq       = item.rx_seq;
        cmd.rx_timestamp = item.rx_timestamp;
        cmd.restart      = item.restart;
        cmd.stat_index   = item.stat_index;
        case (item.func)
            FUNC_PING_REQ: cmd.op = OP_PING_REQ;
            FUNC_TX_DONE:
            begin
                if (item.tx_ok)
                begin
                    cmd.op = item.tx_was_pong ? OP_TX_PONG : OP_TX_PING;
                end
            end
            FUNC_RX_PKT:
            begin
                if (hdr_ok && item.rx_type == TYPE_PING)
                begin
                    cmd.op = OP_RX_PING;
                end
                else if (hdr_ok && item.rx_type == TYPE_PONG)
                begin
                    cmd.op = OP_RX_PONG;
                end
            end
            FUNC_TICK:  cmd.op = OP_TICK;
            FUNC_CLEAR: cmd.op = OP_CLEAR;
            FUNC_READ:  cmd.op = OP_READ;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

### rtl/plt_back.sv
module plt_back
    import plt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  cmd_t        cmd,
    input  logic [31:0] timeout_us,
    output result_t     result
);

    logic [31:0] seq_reg, seq_next;
    logic [31:0] pend_seq_reg, pend_seq_next;
    logic [31:0] pend_time_reg, pend_time_next;
    logic        outst_reg, outst_next;
    logic [31:0] out_seq_reg, out_seq_next;
    logic [31:0] out_time_reg, out_time_next;
    logic [31:0] cnt_reg [NUM_CNT];
    logic [31:0] cnt_next [NUM_CNT];
    logic [31:0] last_rtt_reg, last_rtt_next;
    logic [31:0] min_rtt_reg, min_rtt_next;
    logic [31:0] max_rtt_reg, max_rtt_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] samples_reg, samples_next;

    logic [31:0] elapsed;
    logic        pong_match;
    logic [63:0] stat_sel;

    // wrap-safe age of the outstanding ping
    assign elapsed    = cmd.now_us - out_time_reg;
    assign pong_match = outst_reg && (out_seq_reg == cmd.rx_seq);

    always_comb
    begin
        case (cmd.stat_index)
            STAT_PING_TX:   stat_sel = {32'd0, cnt_reg[CNT_PING_TX]};
            STAT_PING_RX:   stat_sel = {32'd0, cnt_reg[CNT_PING_RX]};
            STAT_PONG_TX:   stat_sel = {32'd0, cnt_reg[CNT_PONG_TX]};
            STAT_PONG_RX:   stat_sel = {32'd0, cnt_reg[CNT_PONG_RX]};
            STAT_TIMEOUT:   stat_sel = {32'd0, cnt_reg[CNT_TIMEOUT]};
            STAT_LAST_RTT:  stat_sel = {32'd0, last_rtt_reg};
            STAT_MIN_RTT:   stat_sel = {32'd0, min_rtt_reg};
            STAT_MAX_RTT:   stat_sel = {32'd0, max_rtt_reg};
            STAT_RTT_TOTAL: stat_sel = total_reg;
            STAT_SAMPLES:   stat_sel = {32'd0, samples_reg};
            STAT_OUT_SEQ:   stat_sel = {32'd0, out_seq_reg};
            STAT_OUT_TIME:  stat_sel = {32'd0, out_time_reg};
            default:        stat_sel = '0;
        endcase
    end

    always_comb
    begin
        seq_next       = seq_reg;
        pend_seq_next  = pend_seq_reg;
        pend_time_next = pend_time_reg;
        outst_next     = outst_reg;
        out_seq_next   = out_seq_reg;
        out_time_next  = out_time_reg;
        cnt_next       = cnt_reg;
        last_rtt_next  = last_rtt_reg;
        min_rtt_next   = min_rtt_reg;
        max_rtt_next   = max_rtt_reg;
        total_next     = total_reg;
        samples_next   = samples_reg;
        result         = '0;

        case (cmd.op)
            OP_PING_REQ:
            begin
                outst_next          = 1'b0;
                seq_next            = seq_reg + 32'd1;
                pend_seq_next       = seq_reg + 32'd1;
                pend_time_next      = cmd.now_us;
                result.tx_request   = 1'b1;
                result.tx_seq       = seq_reg + 32'd1;
                result.tx_timestamp = cmd.now_us;
            end
            OP_TX_PING:
            begin
                outst_next            = 1'b1;
                out_seq_next          = pend_seq_reg;
                out_time_next         = pend_time_reg;
                cnt_next[CNT_PING_TX] = cnt_reg[CNT_PING_TX] + 32'd1;
            end
            OP_TX_PONG:
            begin
                cnt_next[CNT_PONG_TX] = cnt_reg[CNT_PONG_TX] + 32'd1;
            end
            OP_RX_PING:
            begin
                cnt_next[CNT_PING_RX] = cnt_reg[CNT_PING_RX] + 32'd1;
                result.tx_request     = 1'b1;
                result.tx_is_pong     = 1'b1;
                result.tx_seq         = cmd.rx_seq;
                result.tx_timestamp   = cmd.rx_timestamp;
            end
            OP_RX_PONG:
            begin
                if (pong_match)
                begin
                    outst_next            = 1'b0;
                    cnt_next[CNT_PONG_RX] = cnt_reg[CNT_PONG_RX] + 32'd1;
                    last_rtt_next         = elapsed;
                    if (elapsed < min_rtt_reg)
                    begin
                        min_rtt_next = elapsed;
                    end
                    if (elapsed > max_rtt_reg)
                    begin
                        max_rtt_next = elapsed;
                    end
                    total_next       = total_reg + {32'd0, elapsed};
                    samples_next     = samples_reg + 32'd1;
                    result.rtt_valid = 1'b1;
                    result.rtt_us    = elapsed;
                end
            end
            OP_TICK:
            begin
                if (outst_reg && elapsed >= timeout_us)
                begin
                    outst_next            = 1'b0;
                    cnt_next[CNT_TIMEOUT] = cnt_reg[CNT_TIMEOUT] + 32'd1;
                    result.timeout_event  = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_CNT; i++)
                begin
                    cnt_next[i] = '0;
                end
                last_rtt_next = '0;
                min_rtt_next  = '1;
                max_rtt_next  = '0;
                total_next    = '0;
                samples_next  = '0;
                outst_next    = 1'b0;
                out_seq_next  = '0;
                out_time_next = '0;
                if (cmd.restart)
                begin
                    seq_next       = '0;
                    pend_seq_next  = '0;
                    pend_time_next = '0;
                end
            end
            OP_READ:
            begin
                result.stat_value = stat_sel;
            end
            default: ;
        endcase

        result.ping_outstanding = outst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            pend_seq_reg  <= '0;
            pend_time_reg <= '0;
            outst_reg     <= 1'b0;
            out_seq_reg   <= '0;
            out_time_reg  <= '0;
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            last_rtt_reg  <= '0;
            min_rtt_reg   <= '1;
            max_rtt_reg   <= '0;
            total_reg     <= '0;
            samples_reg   <= '0;
        end
        else if (go)
        begin
            seq_reg       <= seq_next;
            pend_seq_reg  <= pend_seq_next;
            pend_time_reg <= pend_time_next;
            outst_reg     <= outst_next;
            out_seq_reg   <= out_seq_next;
            out_time_reg  <= out_time_next;
            cnt_reg       <= cnt_next;
            last_rtt_reg  <= last_rtt_next;
            min_rtt_reg   <= min_rtt_next;
            max_rtt_reg   <= max_rtt_next;
            total_reg     <= total_next;
            samples_reg   <= samples_next;
        end
    end

    a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cmd.op == OP_CLEAR) |=> (!outst_reg && samples_reg == '0))
        else $error("clear left a ping outstanding or samples counted");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (samples_reg != '0) |-> (min_rtt_reg <= max_rtt_reg))
        else $error("min rtt above max rtt");

    a_rtt_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (go && (result.rtt_valid || result.timeout_event)) |=> !outst_reg)
        else $error("ping still outstanding after pong or timeout");

    a_ping_req_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (go && cmd.op == OP_PING_REQ) |=> (seq_reg == $past(seq_reg) + 32'd1))
        else $error("ping request did not advance sequence");

endmodule

### bench/tb.sv
module tb;
    import plt_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // selector and statistic codes the package leaves unnamed
    localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
    localparam logic [3:0] STAT_SPARE    = 4'd15;

    // link state tracker: mirrors the engine and keeps the results still owed
    class link_scoreboard;
        result_t     due[$];
        int          errors;
        bit [31:0]   timeout_us;
        bit [7:0]    frame_len;
        bit [7:0]    magic;
        bit [31:0]   seq_ctr;
        bit [31:0]   pend_seq;
        bit [31:0]   pend_time;
        bit          out_flag;
        bit [31:0]   out_seq;
        bit [31:0]   out_time;
        bit [31:0]   counters [NUM_CNT];
        bit [31:0]   last_rtt;
        bit [31:0]   min_rtt;
        bit [31:0]   max_rtt;
        bit [63:0]   rtt_sum;
        bit [31:0]   sample_cnt;

        function new();
            errors     = 0;
            timeout_us = TIMEOUT_RESET;
            frame_len  = FRAME_LEN_RESET;
            magic      = MAGIC_RESET;
            seq_ctr    = '0;
            pend_seq   = '0;
            pend_time  = '0;
            drop_stats();
        endfunction

        // statistics and the outstanding ping go away together
        function void drop_stats();
            foreach (counters[i])
                counters[i] = '0;
            last_rtt   = '0;
            min_rtt    = '1;
            max_rtt    = '0;
            rtt_sum    = '0;
            sample_cnt = '0;
            out_flag   = 1'b0;
            out_seq    = '0;
            out_time   = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_TIMEOUT:   timeout_us = data;
                CFG_FRAME_LEN: frame_len  = data[7:0];
                CFG_MAGIC:     magic      = data[7:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] statistic(logic [3:0] idx);
            case (idx)
                STAT_PING_TX:   return 64'(counters[CNT_PING_TX]);
                STAT_PING_RX:   return 64'(counters[CNT_PING_RX]);
                STAT_PONG_TX:   return 64'(counters[CNT_PONG_TX]);
                STAT_PONG_RX:   return 64'(counters[CNT_PONG_RX]);
                STAT_TIMEOUT:   return 64'(counters[CNT_TIMEOUT]);
                STAT_LAST_RTT:  return 64'(last_rtt);
                STAT_MIN_RTT:   return 64'(min_rtt);
                STAT_MAX_RTT:   return 64'(max_rtt);
                STAT_RTT_TOTAL: return rtt_sum;
                STAT_SAMPLES:   return 64'(sample_cnt);
                STAT_OUT_SEQ:   return 64'(out_seq);
                STAT_OUT_TIME:  return 64'(out_time);
                default:        return '0;
            endcase
        endfunction

        // advance the mirrored state by one accepted event, queue its result
        function void note_event(in_item_t ev);
            result_t   r;
            bit [31:0] elapsed;
            r = '0;
            elapsed = ev.now_us - out_time;
            case (ev.func)
                FUNC_PING_REQ:
                begin
                    out_flag = 1'b0;
                    seq_ctr += 1;
                    pend_seq  = seq_ctr;
                    pend_time = ev.now_us;
                    r.tx_request   = 1'b1;
                    r.tx_seq       = pend_seq;
                    r.tx_timestamp = pend_time;
                end
                FUNC_TX_DONE:
                begin
                    if (ev.tx_ok && ev.tx_was_pong)
                        counters[CNT_PONG_TX] += 1;
                    else if (ev.tx_ok)
                    begin
                        out_flag = 1'b1;
                        out_seq  = pend_seq;
                        out_time = pend_time;
                        counters[CNT_PING_TX] += 1;
                    end
                end
                FUNC_RX_PKT:
                begin
                    if (ev.rx_length == frame_len && ev.rx_magic == magic)
                    begin
                        if (ev.rx_type == TYPE_PING)
                        begin
                            counters[CNT_PING_RX] += 1;
                            r.tx_request   = 1'b1;
                            r.tx_is_pong   = 1'b1;
                            r.tx_seq       = ev.rx_seq;
                            r.tx_timestamp = ev.rx_timestamp;
                        end
                        else if (ev.rx_type == TYPE_PONG && out_flag && out_seq == ev.rx_seq)
                        begin
                            out_flag = 1'b0;
                            counters[CNT_PONG_RX] += 1;
                            last_rtt = elapsed;
                            if (elapsed < min_rtt)
                                min_rtt = elapsed;
                            if (elapsed > max_rtt)
                                max_rtt = elapsed;
                            rtt_sum    += 64'(elapsed);
                            sample_cnt += 1;
                            r.rtt_valid = 1'b1;
                            r.rtt_us    = elapsed;
                        end
                    end
                end
                FUNC_TICK:
                begin
                    if (out_flag && elapsed >= timeout_us)
                    begin
                        out_flag = 1'b0;
                        counters[CNT_TIMEOUT] += 1;
                        r.timeout_event = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    drop_stats();
                    if (ev.restart)
                    begin
                        seq_ctr   = '0;
                        pend_seq  = '0;
                        pend_time = '0;
                    end
                end
                FUNC_READ:
                    r.stat_value = statistic(ev.stat_index);
                default: ;
            endcase
            r.ping_outstanding = out_flag;
            due.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                $error("result with no item waiting");
                errors++;
                return;
            end
            want = due.pop_front();
            compare("tx_request", 64'(want.tx_request), 64'(got.tx_request));
            compare("tx_is_pong", 64'(want.tx_is_pong), 64'(got.tx_is_pong));
            compare("tx_seq", 64'(want.tx_seq), 64'(got.tx_seq));
            compare("tx_timestamp", 64'(want.tx_timestamp), 64'(got.tx_timestamp));
            compare("rtt_valid", 64'(want.rtt_valid), 64'(got.rtt_valid));
            compare("rtt_us", 64'(want.rtt_us), 64'(got.rtt_us));
            compare("timeout_event", 64'(want.timeout_event), 64'(got.timeout_event));
            compare("ping_outstanding", 64'(want.ping_outstanding),
                    64'(got.ping_outstanding));
            compare("stat_value", want.stat_value, got.stat_value);
        endfunction

        function void final_check();
            if (due.size() != 0)
            begin
                $error("%0d results never arrived", due.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    in_item_t    item      = '0;
    logic        full;
    logic        empty;
    logic        cfg_ready;
    result_t     result;

    link_scoreboard board;

    // microsecond time handed to the engine
    bit [31:0] clock_us;
    // no idling on either side once set
    bit        quiet;
    // idle chances in percent, re-rolled now and then
    int        send_idle_pct;
    int        pop_stall_pct;
    int        items_sent;
    int        cycle_count;

    ping_pong_rtt_link_tester_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: take what is offered, stall in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                board.check_result(result);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < pop_stall_pct)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // random bits in every field, callers overwrite what matters
    function automatic in_item_t noise_item();
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return in_item_t'(noise[$bits(in_item_t)-1:0]);
    endfunction

    // mostly small steps, sometimes long waits, rarely a jump anywhere
    function automatic bit [31:0] tick_forward();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            clock_us = $urandom;
        else if (roll < 6)
            clock_us += $urandom_range(0, 1500000);
        else
            clock_us += $urandom_range(0, 3000);
        return clock_us;
    endfunction

    // offer one item, optionally after an idle burst, and log it when taken
    task automatic send_event(input in_item_t ev);
        if (!quiet && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item <= ev;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        board.note_event(ev);
        items_sent++;
    endtask

    task automatic send_plain(input logic [2:0] func, input logic [31:0] now);
        in_item_t ev;
        ev = noise_item();
        ev.func = func;
        ev.now_us = now;
        send_event(ev);
    endtask

    task automatic send_tx_done(input bit ok, input bit was_pong, input logic [31:0] now);
        in_item_t ev;
        ev = noise_item();
        ev.func = FUNC_TX_DONE;
        ev.now_us = now;
        ev.tx_ok = ok;
        ev.tx_was_pong = was_pong;
        send_event(ev);
    endtask

    task automatic send_packet(input logic [7:0] len, input logic [7:0] lead,
                               input logic [7:0] kind, input logic [31:0] seq,
                               input logic [31:0] stamp, input logic [31:0] now);
        in_item_t ev;
        ev = noise_item();
        ev.func = FUNC_RX_PKT;
        ev.now_us = now;
        ev.rx_length = len;
        ev.rx_magic = lead;
        ev.rx_type = kind;
        ev.rx_seq = seq;
        ev.rx_timestamp = stamp;
        send_event(ev);
    endtask

    task automatic send_clear(input bit restart);
        in_item_t ev;
        ev = noise_item();
        ev.func = FUNC_CLEAR;
        ev.now_us = clock_us;
        ev.restart = restart;
        send_event(ev);
    endtask

    task automatic send_read(input logic [3:0] idx);
        in_item_t ev;
        ev = noise_item();
        ev.func = FUNC_READ;
        ev.now_us = clock_us;
        ev.stat_index = idx;
        send_event(ev);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic wait_settled(input int extra);
        push <= 1'b0;
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // config valid stays up across the three writes, drops after the last
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic apply_settings(input logic [31:0] tmo, input logic [31:0] len,
                                  input logic [31:0] lead);
        write_register(CFG_TIMEOUT, tmo);
        write_register(CFG_FRAME_LEN, len);
        write_register(CFG_MAGIC, lead);
        cfg_valid <= 1'b0;
    endtask

    // one event of any kind, weighted toward things that change state
    function automatic in_item_t pick_event();
        in_item_t ev;
        int       pick;
        ev = noise_item();
        ev.now_us = tick_forward();
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ev.func = FUNC_PING_REQ;
        else if (pick < 25)
        begin
            ev.func = FUNC_TX_DONE;
            ev.tx_ok = ($urandom_range(0, 4) != 0);
        end
        else if (pick < 40)
        begin
            // peer ping that deserves a pong
            ev.func = FUNC_RX_PKT;
            ev.rx_length = board.frame_len;
            ev.rx_magic = board.magic;
            ev.rx_type = TYPE_PING;
        end
        else if (pick < 50)
        begin
            // broken packet: one thing wrong, or all of it random
            ev.func = FUNC_RX_PKT;
            ev.rx_length = board.frame_len;
            ev.rx_magic = board.magic;
            ev.rx_type = TYPE_PONG;
            ev.rx_seq = board.out_seq;
            case ($urandom_range(0, 4))
                0: ev.rx_length = board.frame_len + 8'($urandom_range(1, 255));
                1: ev.rx_magic = board.magic + 8'($urandom_range(1, 255));
                2: ev.rx_type = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(3, 255));
                3: ev.rx_seq = board.out_seq ^ (32'd1 << $urandom_range(0, 31));
                default: ev = noise_item();
            endcase
            ev.func = FUNC_RX_PKT;
        end
        else if (pick < 62)
            ev.func = FUNC_TICK;
        else if (pick < 66)
            ev.func = FUNC_CLEAR;
        else if (pick < 95)
            ev.func = FUNC_READ;
        else
            ev.func = $urandom_range(0, 1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
        return ev;
    endfunction

    // a full round trip: request, transmit report, maybe noise or a tick, then the pong and maybe a read
    task automatic play_round();
        send_plain(FUNC_PING_REQ, tick_forward());
        if ($urandom_range(0, 9) != 0)
            send_tx_done(1'b1, 1'b0, tick_forward());
        else
            send_tx_done(1'b0, 1'($urandom_range(0, 1)), tick_forward());
        repeat ($urandom_range(0, 2)) send_event(pick_event());
        if ($urandom_range(0, 4) == 0)
            send_plain(FUNC_TICK, tick_forward());
        send_packet(board.frame_len, board.magic, TYPE_PONG,
                    ($urandom_range(0, 9) == 0) ? 32'($urandom) : board.out_seq,
                    $urandom, tick_forward());
        if ($urandom_range(0, 3) == 0)
            send_read(4'($urandom_range(0, 15)));
    endtask

    task automatic run_phase(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                send_idle_pct = $urandom_range(0, 2) * 15;
                pop_stall_pct = $urandom_range(0, 2) * 15;
            end
            // now and then let the engine run dry before going on
            if ($urandom_range(0, 149) == 0)
                wait_settled(0);
            if ($urandom_range(0, 9) < 6)
                play_round();
            else
                send_event(pick_event());
        end
    endtask

    // hand-picked events against the reset configuration
    task automatic run_directed();
        in_item_t ev;
        send_read(STAT_MIN_RTT);
        send_read(STAT_SPARE);
        // transmit report with no request commits the zero pending ping
        send_tx_done(1'b1, 1'b0, 32'd5);
        // one short of the timeout, then exactly on it
        send_plain(FUNC_TICK, 32'd999999);
        send_plain(FUNC_TICK, 32'd1000000);
        send_plain(FUNC_PING_REQ, 32'hFFFF_FF00);
        send_tx_done(1'b0, 1'b0, 32'hFFFF_FF10);
        send_tx_done(1'b1, 1'b1, 32'hFFFF_FF20);
        send_tx_done(1'b1, 1'b0, 32'hFFFF_FF30);
        // pongs that must be ignored: wrong seq, magic, length, type
        send_packet(FRAME_LEN_RESET, MAGIC_RESET, TYPE_PONG, 32'd2, 32'd0, 32'h10);
        send_packet(FRAME_LEN_RESET, 8'h5A, TYPE_PONG, 32'd1, 32'd0, 32'h20);
        send_packet(8'd43, MAGIC_RESET, TYPE_PONG, 32'd1, 32'd0, 32'h30);
        send_packet(FRAME_LEN_RESET, MAGIC_RESET, 8'hFF, 32'd1, 32'd0, 32'h40);
        // matching pong across the time wrap
        send_packet(FRAME_LEN_RESET, MAGIC_RESET, TYPE_PONG, 32'd1, 32'hDEAD, 32'h100);
        // peer ping with every field at its top value
        ev = '1;
        ev.func = FUNC_RX_PKT;
        ev.rx_length = FRAME_LEN_RESET;
        ev.rx_magic = MAGIC_RESET;
        ev.rx_type = TYPE_PING;
        send_event(ev);
        send_read(STAT_RTT_TOTAL);
        ev = '1;
        ev.func = FUNC_SPARE_HI;
        send_event(ev);
        send_plain(FUNC_SPARE_LO, 32'd0);
        // all-zero item is a ping request at time zero
        send_event('0);
        send_tx_done(1'b1, 1'b0, 32'd50);
        send_clear(1'b0);
        send_read(STAT_OUT_SEQ);
        send_plain(FUNC_PING_REQ, 32'd60);
        send_clear(1'b1);
        send_read(STAT_MIN_RTT);
        send_plain(FUNC_PING_REQ, 32'd7);
    endtask

    initial
    begin
        board = new();
        clock_us = '0;
        quiet = 1'b0;
        send_idle_pct = 15;
        pop_stall_pct = 15;
        items_sent = 0;
        cycle_count = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_settled(0);

        // defaults written explicitly
        apply_settings(TIMEOUT_RESET, 32'(FRAME_LEN_RESET), 32'(MAGIC_RESET));
        run_phase(300);
        wait_settled(0);

        // zero timeout, shortest frame, zero magic, time near the wrap
        apply_settings(32'd0, 32'd1, 32'd0);
        clock_us = 32'hFFFF_F000;
        run_phase(250);
        wait_settled(0);

        // longest timeout, longest frame, all-ones magic
        apply_settings(32'hFFFF_FFFF, 32'd255, 32'hFF);
        run_phase(250);
        wait_settled(0);

        // short random timeout, junk in the unused upper data bits
        apply_settings($urandom_range(1, 5000),
                       {24'($urandom), 8'($urandom_range(1, 255))}, $urandom);
        run_phase(250);
        wait_settled(0);

        // closing stretch at full rate, no idling anywhere
        quiet = 1'b1;
        apply_settings(32'd1, $urandom_range(1, 255), $urandom_range(0, 255));
        run_phase(150);

        wait_settled(DRAIN_CYCLES);
        board.final_check();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### ping_pong_rtt_link_tester_core.f
rtl/plt_pkg.sv
rtl/plt_fifo.sv
rtl/plt_front.sv
rtl/plt_back.sv
rtl/ping_pong_rtt_link_tester_core.sv
bench/tb.sv
